>>> sv/lcs_pkg.sv
package lcs_pkg;

	localparam int AngW = 16;
	localparam int RngW = 18;
	localparam int CntW = 14;
	localparam int CordW = 33;
	localparam int ZW = 34;
	localparam int PtW = 24;
	localparam int MaxSteps = 24;

	localparam logic [CordW-1:0] GainQ30 = 33'd652032874;

	typedef enum logic [1:0] {
		CFG_QUALITY = 2'd0,
		CFG_JUMP = 2'd1,
		CFG_MINPTS = 2'd2,
		CFG_WIDTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [AngW-1:0] fa;
		logic [RngW-1:0] fr;
		logic [AngW-1:0] ba;
		logic [RngW-1:0] br;
		logic [CntW-1:0] cnt;
	} clu_t;

	typedef struct packed {
		logic start;
		logic [AngW-1:0] ang;
	} cord_req_t;

	typedef struct packed {
		logic done;
		logic signed [CordW-1:0] c;
		logic signed [CordW-1:0] s;
	} cord_rsp_t;

	function automatic logic [ZW-1:0] atan_q(input logic [4:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0: v = 34'd536870912;
			5'd1: v = 34'd316933406;
			5'd2: v = 34'd167458907;
			5'd3: v = 34'd85004756;
			5'd4: v = 34'd42667331;
			5'd5: v = 34'd21354465;
			5'd6: v = 34'd10680862;
			5'd7: v = 34'd5340245;
			5'd8: v = 34'd2670163;
			5'd9: v = 34'd1335087;
			5'd10: v = 34'd667544;
			5'd11: v = 34'd333772;
			5'd12: v = 34'd166886;
			5'd13: v = 34'd83443;
			5'd14: v = 34'd41721;
			5'd15: v = 34'd20860;
			5'd16: v = 34'd10430;
			5'd17: v = 34'd5215;
			5'd18: v = 34'd2607;
			5'd19: v = 34'd1303;
			5'd20: v = 34'd651;
			5'd21: v = 34'd325;
			5'd22: v = 34'd162;
			5'd23: v = 34'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_JOINCHK,
		ST_CHK,
		ST_C1,
		ST_W1,
		ST_M1X,
		ST_M1Y,
		ST_C2,
		ST_W2,
		ST_M2X,
		ST_M2Y,
		ST_DX,
		ST_DY,
		ST_CMP,
		ST_MID,
		ST_EMIT,
		ST_NEXT,
		ST_MARK,
		ST_SETTLE
	} seq_t;

endpackage

>>> sv/lcs_cordic.sv
module lcs_cordic #(
	parameter int STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input lcs_pkg::cord_req_t req,
	output lcs_pkg::cord_rsp_t rsp
);
	localparam int NS = (STEPS < lcs_pkg::MaxSteps) ? STEPS : lcs_pkg::MaxSteps;

	logic signed [lcs_pkg::CordW-1:0] x_q, y_q;
	logic signed [lcs_pkg::ZW-1:0] z_q;
	logic [4:0] i_q;
	logic [1:0] quad_q;
	logic busy_q;
	logic signed [lcs_pkg::CordW-1:0] xs, ys;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == 5'(NS - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= lcs_pkg::GainQ30;
			y_q <= '0;
			z_q <= {4'b0000, req.ang[13:0], 16'd0};
			quad_q <= req.ang[15:14];
		end else if (busy_q) begin
			if (!z_q[lcs_pkg::ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed(lcs_pkg::atan_q(i_q));
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed(lcs_pkg::atan_q(i_q));
			end
		end
	end

	// z is angle in Q32 per turn: 14 bits of quadrant angle shifted by 16
	always_comb begin
		rsp.done = !busy_q && !req.start;
		case (quad_q)
			2'd0: begin rsp.c = x_q; rsp.s = y_q; end
			2'd1: begin rsp.c = -y_q; rsp.s = x_q; end
			2'd2: begin rsp.c = -x_q; rsp.s = -y_q; end
			default: begin rsp.c = y_q; rsp.s = -x_q; end
		endcase
	end
endmodule

>>> sv/lidar_cone_segmenter.sv
// Lidar cone segmenter.
// Input channel: angle_code, range_code, quality_byte, scan_last with in_valid/in_stall.
// Output channel: cone_x, cone_y, cone_valid, scan_done with out_valid/out_stall.
// Config: APB-style port, registers at 0x0 quality, 0x4 jump, 0x8 min points, 0xC width.
// A sample that closes no cluster is accepted and then takes one update step.
// A cluster under the point count is dropped at once; any other is judged by two rotations,
// the products and the chord test, and one that becomes a cone adds a midpoint and emit step;
// the time is set by the single shared CORDIC rotator and one shared multiplier run in turn.
// A scan end adds a settle step, judges up to two clusters and then sends a marker item.
// in_stall stays high while a sample is in work; a waiting result does not block input.
// While out_stall is high the result register holds and the sequencer waits to emit.
// Reset restores the register defaults and clears all cluster state.
// Up to four items (three cones, one marker) may follow one input sample.
module lidar_cone_segmenter #(
	parameter int MAX_SCAN_POINTS = 8192,
	parameter int QUALITY_SHIFT = 2,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] angle_code,
	input logic [17:0] range_code,
	input logic [7:0] quality_byte,
	input logic scan_last,
	output logic out_valid,
	input logic out_stall,
	output logic signed [18:0] cone_x,
	output logic signed [18:0] cone_y,
	output logic cone_valid,
	output logic scan_done,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CntCap = (MAX_SCAN_POINTS < 16383) ? MAX_SCAN_POINTS : 16383;
	localparam int CW = lcs_pkg::CntW;
	localparam int PW = lcs_pkg::PtW;

	logic [5:0] qual_q;
	logic [17:0] jump_q, width_q;
	logic [13:0] minp_q;

	logic [17:0] prev_q;
	logic have_q, fheld_q;
	lcs_pkg::clu_t open_q, first_q;

	logic [15:0] ang_q;
	logic [17:0] rng_q;
	logic [7:0] qb_q;
	logic last_q;

	lcs_pkg::seq_t st_q, st_d;
	lcs_pkg::clu_t job_q, job2_q;
	logic job2_vld_q;
	logic settled_q;

	lcs_pkg::cord_req_t creq;
	lcs_pkg::cord_rsp_t crsp;

	logic signed [PW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [lcs_pkg::CordW-1:0] c_q, s_q;
	logic [PW:0] dx_q, dy_q;
	logic [50:0] d2_q;

	logic signed [18:0] ox_q, oy_q;
	logic ocv_q, osd_q, ov_q;

	// shared multiplier
	logic signed [PW+1:0] ma;
	logic signed [lcs_pkg::CordW:0] mb;
	logic signed [lcs_pkg::CordW+PW+1:0] mp;
	logic [lcs_pkg::CordW+PW+1:0] mrnd;
	logic signed [PW-1:0] mq;
	assign mp = ma * mb;
	assign mrnd = mp + {{(lcs_pkg::CordW+PW-24){1'b0}}, 1'b1, 25'd0};
	assign mq = PW'($signed(mrnd) >>> 26);

	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			lcs_pkg::CFG_QUALITY: prdata = {26'd0, qual_q};
			lcs_pkg::CFG_JUMP: prdata = {14'd0, jump_q};
			lcs_pkg::CFG_MINPTS: prdata = {18'd0, minp_q};
			lcs_pkg::CFG_WIDTH: prdata = {14'd0, width_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qual_q <= 6'd47;
			jump_q <= 18'd800;
			minp_q <= 14'd5;
			width_q <= 18'd920;
		end else if (wr) begin
			case (paddr[3:2])
				lcs_pkg::CFG_QUALITY: qual_q <= pwdata[5:0];
				lcs_pkg::CFG_JUMP: jump_q <= pwdata[17:0];
				lcs_pkg::CFG_MINPTS: minp_q <= pwdata[13:0];
				lcs_pkg::CFG_WIDTH: width_q <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	logic acc;
	assign in_stall = (st_q != lcs_pkg::ST_IDLE);
	assign acc = in_valid && !in_stall;

	logic use_smp;
	logic close_job;
	logic [17:0] d_prev, d_wrap;
	logic [CW:0] join_sum;
	lcs_pkg::clu_t newc, joinc;
	logic [CW-1:0] inc_cnt;
	assign use_smp = (qb_q >> QUALITY_SHIFT) == {2'b00, qual_q};
	assign d_prev = (rng_q > prev_q) ? rng_q - prev_q : prev_q - rng_q;
	assign d_wrap = (first_q.fr > open_q.br) ? first_q.fr - open_q.br : open_q.br - first_q.fr;
	assign close_job = use_smp && have_q && (d_prev > jump_q) && fheld_q;
	assign join_sum = {1'b0, open_q.cnt} + {1'b0, first_q.cnt};
	assign inc_cnt = (open_q.cnt >= CW'(CntCap)) ? CW'(CntCap) : open_q.cnt + 1'b1;
	assign newc = '{fa: ang_q, fr: rng_q, ba: ang_q, br: rng_q, cnt: CW'(1)};
	always_comb begin
		joinc = open_q;
		joinc.ba = first_q.ba;
		joinc.br = first_q.br;
		joinc.cnt = (join_sum > (CW+1)'(CntCap)) ? CW'(CntCap) : join_sum[CW-1:0];
	end

	logic cord_done;
	assign cord_done = crsp.done;

	always_comb begin
		st_d = st_q;
		creq.start = 1'b0;
		creq.ang = job_q.fa;
		ma = '0;
		mb = '0;
		case (st_q)
			lcs_pkg::ST_IDLE: if (acc) st_d = lcs_pkg::ST_JOINCHK;
			lcs_pkg::ST_JOINCHK: st_d = close_job ? lcs_pkg::ST_CHK :
				(last_q ? lcs_pkg::ST_SETTLE : lcs_pkg::ST_IDLE);
			lcs_pkg::ST_SETTLE: st_d = have_q ? lcs_pkg::ST_CHK : lcs_pkg::ST_MARK;
			lcs_pkg::ST_CHK: st_d = (job_q.cnt < minp_q) ? lcs_pkg::ST_NEXT : lcs_pkg::ST_C1;
			lcs_pkg::ST_C1: begin creq.start = 1'b1; st_d = lcs_pkg::ST_W1; end
			lcs_pkg::ST_W1: if (cord_done) st_d = lcs_pkg::ST_M1X;
			lcs_pkg::ST_M1X: begin
				ma = {8'd0, job_q.fr}; mb = {c_q[lcs_pkg::CordW-1], c_q};
				st_d = lcs_pkg::ST_M1Y;
			end
			lcs_pkg::ST_M1Y: begin
				ma = {8'd0, job_q.fr}; mb = {s_q[lcs_pkg::CordW-1], s_q};
				st_d = lcs_pkg::ST_C2;
			end
			lcs_pkg::ST_C2: begin
				creq.start = 1'b1; creq.ang = job_q.ba; st_d = lcs_pkg::ST_W2;
			end
			lcs_pkg::ST_W2: if (cord_done) st_d = lcs_pkg::ST_M2X;
			lcs_pkg::ST_M2X: begin
				ma = {8'd0, job_q.br}; mb = {c_q[lcs_pkg::CordW-1], c_q};
				st_d = lcs_pkg::ST_M2Y;
			end
			lcs_pkg::ST_M2Y: begin
				ma = {8'd0, job_q.br}; mb = {s_q[lcs_pkg::CordW-1], s_q};
				st_d = lcs_pkg::ST_DX;
			end
			lcs_pkg::ST_DX: begin
				ma = $signed({1'b0, dx_q}); mb = $signed({9'd0, dx_q}); st_d = lcs_pkg::ST_DY;
			end
			lcs_pkg::ST_DY: begin
				ma = $signed({1'b0, dy_q}); mb = $signed({9'd0, dy_q}); st_d = lcs_pkg::ST_CMP;
			end
			lcs_pkg::ST_CMP: begin
				// square the width limit on the shared multiplier
				ma = {4'd0, width_q, 4'd0}; mb = {12'd0, width_q, 4'd0};
				st_d = (d2_q > 51'(mp)) ? lcs_pkg::ST_NEXT : lcs_pkg::ST_MID;
			end
			lcs_pkg::ST_MID: st_d = lcs_pkg::ST_EMIT;
			lcs_pkg::ST_EMIT: if (!ov_q) st_d = lcs_pkg::ST_NEXT;
			lcs_pkg::ST_NEXT: begin
				if (job2_vld_q) st_d = lcs_pkg::ST_CHK;
				else if (last_q && !settled_q) st_d = lcs_pkg::ST_SETTLE;
				else if (last_q) st_d = lcs_pkg::ST_MARK;
				else st_d = lcs_pkg::ST_IDLE;
			end
			lcs_pkg::ST_MARK: if (!ov_q) st_d = lcs_pkg::ST_IDLE;
			default: st_d = lcs_pkg::ST_IDLE;
		endcase
	end

	logic signed [PW:0] sx, sy;
	logic signed [PW:0] rx, ry;
	assign sx = (PW+1)'(x1_q) + (PW+1)'(x2_q) + (PW+1)'(16);
	assign sy = (PW+1)'(y1_q) + (PW+1)'(y2_q) + (PW+1)'(16);
	assign rx = sx >>> 5;
	assign ry = sy >>> 5;

	function automatic logic signed [18:0] sat19(input logic signed [PW:0] v);
		if (v > 262143) return 19'sd262143;
		if (v < -262144) return -19'sd262144;
		return v[18:0];
	endfunction

	logic load_cone, load_mark;
	assign load_cone = (st_q == lcs_pkg::ST_EMIT) && !ov_q;
	assign load_mark = (st_q == lcs_pkg::ST_MARK) && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lcs_pkg::ST_IDLE;
			ov_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			ocv_q <= 1'b0;
			osd_q <= 1'b0;
			prev_q <= '0;
			have_q <= 1'b0;
			fheld_q <= 1'b0;
			open_q <= '0;
			first_q <= '0;
			job_q <= '0;
			job2_q <= '0;
			job2_vld_q <= 1'b0;
			settled_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_cone || load_mark) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				lcs_pkg::ST_JOINCHK: begin
					if (use_smp) begin
						prev_q <= rng_q;
						if (have_q && d_prev <= jump_q) begin
							open_q.ba <= ang_q;
							open_q.br <= rng_q;
							open_q.cnt <= inc_cnt;
						end else begin
							have_q <= 1'b1;
							open_q <= newc;
							if (have_q && !fheld_q) begin
								fheld_q <= 1'b1;
								first_q <= open_q;
							end
						end
					end
					if (close_job) job_q <= open_q;
				end
				// scan end: join across the wrap or queue open then first
				lcs_pkg::ST_SETTLE: begin
					settled_q <= 1'b1;
					if (fheld_q && d_wrap < jump_q) begin
						job_q <= joinc;
					end else begin
						job_q <= open_q;
						if (fheld_q) begin
							job2_q <= first_q;
							job2_vld_q <= 1'b1;
						end
					end
				end
				lcs_pkg::ST_NEXT: begin
					if (job2_vld_q) begin
						job_q <= job2_q;
						job2_vld_q <= 1'b0;
					end
				end
				lcs_pkg::ST_EMIT: begin
					if (!ov_q) begin
						ox_q <= sat19(rx);
						oy_q <= sat19(ry);
						ocv_q <= 1'b1;
						osd_q <= 1'b0;
					end
				end
				lcs_pkg::ST_MARK: begin
					if (!ov_q) begin
						ox_q <= '0;
						oy_q <= '0;
						ocv_q <= 1'b0;
						osd_q <= 1'b1;
						have_q <= 1'b0;
						fheld_q <= 1'b0;
						prev_q <= '0;
						open_q <= '0;
						first_q <= '0;
						settled_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ang_q <= angle_code;
			rng_q <= range_code;
			qb_q <= quality_byte;
			last_q <= scan_last;
		end
		if (crsp.done) begin
			c_q <= crsp.c;
			s_q <= crsp.s;
		end
		case (st_q)
			lcs_pkg::ST_M1X: x1_q <= mq;
			lcs_pkg::ST_M1Y: y1_q <= mq;
			lcs_pkg::ST_M2X: x2_q <= mq;
			lcs_pkg::ST_M2Y: begin
				y2_q <= mq;
				dx_q <= (x1_q >= x2_q) ? (PW+1)'(x1_q) - (PW+1)'(x2_q) :
					(PW+1)'(x2_q) - (PW+1)'(x1_q);
			end
			lcs_pkg::ST_DX: begin
				d2_q <= 51'(mp);
				dy_q <= (y1_q >= y2_q) ? (PW+1)'(y1_q) - (PW+1)'(y2_q) :
					(PW+1)'(y2_q) - (PW+1)'(y1_q);
			end
			lcs_pkg::ST_DY: d2_q <= d2_q + 51'(mp);
			default: ;
		endcase
	end

	lcs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp)
	);

	assign out_valid = ov_q;
	assign cone_x = ox_q;
	assign cone_y = oy_q;
	assign cone_valid = ocv_q;
	assign scan_done = osd_q;

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != lcs_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cone_valid != scan_done))
		else $error("result kind bad");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable({cone_x, cone_y, cone_valid, scan_done}))
		else $error("result changed while stalled");
endmodule

>>> dv/lidar_cone_segmenter_tb.sv
module lidar_cone_segmenter_tb;

	localparam int QSHIFT = 2;
	localparam int CSTEPS = 16;
	localparam int CAP = 8192;

	typedef struct packed {
		logic [15:0] ang;
		logic [17:0] rng;
		logic [7:0] qb;
		logic last;
	} sample_t;

	typedef struct packed {
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic cv;
		logic sd;
	} cone_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] angle_code = '0;
	logic [17:0] range_code = '0;
	logic [7:0] quality_byte = '0;
	logic scan_last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [18:0] cone_x, cone_y;
	logic cone_valid, scan_done;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lidar_cone_segmenter dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [5:0] m_qual;
	logic [17:0] m_jump, m_wid;
	logic [13:0] m_minp;
	logic [17:0] prev_rng;
	logic have_clu, first_held;
	lcs_pkg::clu_t open_c, first_c;

	sample_t pending_q[$];
	cone_t cones_due[$];
	int errors = 0;
	int n_cones = 0, n_scans = 0, n_items = 0;
	bit calm = 0;
	bit hold_tx = 0;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sat19(longint v);
		if (v > 262143) return 262143;
		if (v < -262144) return -262144;
		return v;
	endfunction

	function automatic logic [13:0] cnt_add(logic [13:0] a, logic [13:0] b);
		int t;
		t = a + b;
		return (t > CAP) ? 14'(CAP) : 14'(t);
	endfunction

	function automatic longint atan_at(int i);
		return longint'(lcs_pkg::atan_q(5'(i)));
	endfunction

	task automatic queue_item(input sample_t t);
		pending_q.insert(pending_q.size(), t);
	endtask

	task automatic queue_result(input cone_t r);
		cones_due.insert(cones_due.size(), r);
	endtask

	task automatic rotate(input logic [15:0] a, output longint c, output longint s);
		longint x, y, z, xs, ys;
		x = 652032874;
		y = 0;
		z = longint'(a[13:0]) << 16;
		for (int i = 0; i < CSTEPS && i < 24; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_at(i);
			end else begin
				x += ys; y -= xs; z += atan_at(i);
			end
		end
		case (a[15:14])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic judge(input lcs_pkg::clu_t k);
		longint c1, s1, c2, s2, x1, y1, x2, y2, dx, dy, lim, d2;
		cone_t r;
		if (k.cnt < m_minp) return;
		rotate(k.fa, c1, s1);
		rotate(k.ba, c2, s2);
		x1 = rshr(longint'(k.fr) * c1, 26);
		y1 = rshr(longint'(k.fr) * s1, 26);
		x2 = rshr(longint'(k.br) * c2, 26);
		y2 = rshr(longint'(k.br) * s2, 26);
		dx = x1 - x2; if (dx < 0) dx = -dx;
		dy = y1 - y2; if (dy < 0) dy = -dy;
		d2 = dx * dx + dy * dy;
		lim = (longint'(m_wid) << 4) * (longint'(m_wid) << 4);
		if (d2 > lim) return;
		r.x = 19'(sat19(rshr(x1 + x2, 5)));
		r.y = 19'(sat19(rshr(y1 + y2, 5)));
		r.cv = 1;
		r.sd = 0;
		queue_result(r);
	endtask

	task automatic clear_scan();
		prev_rng = 0; have_clu = 0; first_held = 0;
		open_c = '0; first_c = '0;
	endtask

	task automatic predict(input sample_t t);
		logic [17:0] d;
		bit open_new;
		lcs_pkg::clu_t j;
		cone_t mk;
		if ((t.qb >> QSHIFT) == m_qual) begin
			open_new = 1;
			if (have_clu) begin
				d = (t.rng > prev_rng) ? t.rng - prev_rng : prev_rng - t.rng;
				if (d > m_jump) begin
					if (!first_held) begin
						first_held = 1;
						first_c = open_c;
					end else
						judge(open_c);
				end else begin
					open_new = 0;
					open_c.ba = t.ang;
					open_c.br = t.rng;
					open_c.cnt = cnt_add(open_c.cnt, 1);
				end
			end
			if (open_new) begin
				have_clu = 1;
				open_c.fa = t.ang; open_c.fr = t.rng;
				open_c.ba = t.ang; open_c.br = t.rng;
				open_c.cnt = 1;
			end
			prev_rng = t.rng;
		end
		if (t.last) begin
			if (have_clu) begin
				if (first_held) begin
					d = (first_c.fr > open_c.br) ? first_c.fr - open_c.br
						: open_c.br - first_c.fr;
					if (d < m_jump) begin
						j = open_c;
						j.ba = first_c.ba;
						j.br = first_c.br;
						j.cnt = cnt_add(open_c.cnt, first_c.cnt);
						judge(j);
					end else begin
						judge(open_c);
						judge(first_c);
					end
				end else
					judge(open_c);
			end
			mk = '{x: '0, y: '0, cv: 1'b0, sd: 1'b1};
			queue_result(mk);
			clear_scan();
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict({angle_code, range_code, quality_byte, scan_last});
				n_items++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() != 0 && !hold_tx && (calm || $urandom_range(99) >= 10)) begin
					{angle_code, range_code, quality_byte, scan_last} <= pending_q.pop_front();
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cone_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cones_due.size() == 0) begin
					$error("unexpected item x=%0d y=%0d", cone_x, cone_y);
					errors++;
				end else begin
					e = cones_due.pop_front();
					if (cone_x !== e.x) begin
						$error("cone_x expected %0d got %0d", e.x, cone_x); errors++;
					end
					if (cone_y !== e.y) begin
						$error("cone_y expected %0d got %0d", e.y, cone_y); errors++;
					end
					if (cone_valid !== e.cv) begin
						$error("cone_valid expected %0d got %0d", e.cv, cone_valid); errors++;
					end
					if (scan_done !== e.sd) begin
						$error("scan_done expected %0d got %0d", e.sd, scan_done); errors++;
					end
					if (e.cv) n_cones++;
					if (e.sd) n_scans++;
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 10);
		end
	end

	task automatic reg_write(input lcs_pkg::cfg_reg_t idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			lcs_pkg::CFG_QUALITY: m_qual = v[5:0];
			lcs_pkg::CFG_JUMP: m_jump = v[17:0];
			lcs_pkg::CFG_MINPTS: m_minp = v[13:0];
			default: m_wid = v[17:0];
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || cones_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [7:0] good_q();
		return {m_qual, 2'(($urandom))};
	endfunction

	// one scan of cone-like clusters with random content
	task automatic add_scan(input int nclu, input int rate_bad);
		int a;
		logic [17:0] r;
		int npts;
		a = $urandom_range(65535);
		for (int c = 0; c < nclu; c++) begin
			r = 18'($urandom_range(200, 40000));
			if ($urandom_range(9) == 0) r = 18'($urandom);
			npts = $urandom_range(1, 9);
			for (int p = 0; p < npts; p++) begin
				sample_t t;
				t.ang = 16'(a);
				t.rng = r + 18'($urandom_range(m_jump / 4 + 1));
				t.qb = ($urandom_range(99) < rate_bad) ? 8'($urandom) : good_q();
				t.last = 0;
				queue_item(t);
				a += $urandom_range(1, 60);
			end
		end
		pending_q[$].last = 1;
	endtask

	initial begin
		m_qual = 47; m_jump = 800; m_minp = 5; m_wid = 920;
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty scan, lone cluster, wrap join, extreme fields
		queue_item('{ang: 16'h0000, rng: 18'd0, qb: 8'hFF, last: 1'b1});
		for (int i = 0; i < 6; i++)
			queue_item('{ang: 16'(i * 8), rng: 18'd4000, qb: 8'd188, last: 1'(i == 5)});
		for (int i = 0; i < 5; i++)
			queue_item('{ang: 16'(16'hFFF0 + i), rng: 18'd3000, qb: 8'd191, last: 0});
		for (int i = 0; i < 5; i++)
			queue_item('{ang: 16'(16'h8000 + i), rng: 18'h3FFFF, qb: 8'd189,
				last: 0});
		for (int i = 0; i < 5; i++)
			queue_item('{ang: 16'(16'h4000 + i * 100), rng: 18'd3100, qb: 8'd190,
				last: 1'(i == 4)});
		queue_item('{ang: 16'h7FFF, rng: 18'd100, qb: 8'd0, last: 1'b1});
		drain();

		// sweep registers through extremes; min_points top at the count cap
		reg_write(lcs_pkg::CFG_QUALITY, 0);
		reg_write(lcs_pkg::CFG_JUMP, 18'h3FFFF);
		reg_write(lcs_pkg::CFG_MINPTS, 1);
		reg_write(lcs_pkg::CFG_WIDTH, 18'h3FFFF);
		for (int s = 0; s < 8; s++) add_scan($urandom_range(1, 3), 5);
		drain();
		reg_write(lcs_pkg::CFG_QUALITY, 63);
		reg_write(lcs_pkg::CFG_JUMP, 0);
		reg_write(lcs_pkg::CFG_MINPTS, 8192);
		reg_write(lcs_pkg::CFG_WIDTH, 0);
		for (int s = 0; s < 5; s++) add_scan($urandom_range(1, 4), 10);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			reg_write(lcs_pkg::CFG_QUALITY, $urandom_range(63));
			reg_write(lcs_pkg::CFG_JUMP, (ph == 5) ? 18'h3FFFF : $urandom_range(50, 3000));
			reg_write(lcs_pkg::CFG_MINPTS, $urandom_range(1, 4));
			reg_write(lcs_pkg::CFG_WIDTH, (ph == 4) ? 0 : $urandom_range(100, 20000));
			calm = (ph == 2);
			for (int s = 0; s < 4; s++) add_scan($urandom_range(1, 4), 15);
			// hold off the sender once until all results are in
			if (ph == 3) begin
				while (pending_q.size() > 10) @(posedge clk);
				hold_tx = 1;
				while (in_valid || cones_due.size() != 0) @(posedge clk);
				hold_tx = 0;
			end
			drain();
		end
		calm = 0;
		$display("ran %0d samples over %0d scans, %0d cones checked",
			n_items, n_scans, n_cones);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
